// ===== sv/kce_pkg.sv =====
// Shared types and constants of the k-means clustering engine.
// No dependencies; imported by every other module of the block.
package kce_pkg;

	localparam int VAL_W      = 16;
	localparam int MEAN_W     = 24;
	localparam int FRAC_W     = 8;
	localparam int PORT_DIMS  = 4;
	localparam int CID_W      = 3;
	localparam int CNT_OUT_W  = 11;
	localparam int ITER_W     = 8;
	localparam int THR_W      = 24;
	localparam int DIFF_W     = 26;
	localparam int SQ_W       = 48;
	localparam int DIST_W     = 51;
	localparam int ROOT_W     = 52;
	localparam int ROOT_TOP   = 50;
	localparam int ROOT_STEPS = 26;
	localparam int SHIFT_W    = 32;
	localparam int IN_DATA_W  = 72;
	localparam int OUT_DATA_W = 120;

	typedef enum logic [1:0] {
		ACT_SAMPLE = 2'd0,
		ACT_CENT   = 2'd1,
		ACT_RUN    = 2'd2,
		ACT_NONE   = 2'd3
	} kce_act_t;

	localparam logic [1:0] REG_CLUSTERS  = 2'd0;
	localparam logic [1:0] REG_DIMS      = 2'd1;
	localparam logic [1:0] REG_MAX_ITER  = 2'd2;
	localparam logic [1:0] REG_THRESHOLD = 2'd3;

	typedef enum logic [4:0] {
		S_IDLE, S_RUN_INIT, S_PASS_INIT,
		S_ASG_RD, S_ASG_LAT, S_ASG_CL, S_ASG_DIFF, S_ASG_SQ, S_ASG_ACC, S_ASG_WB,
		S_UPD_C, S_UPD_DIV0, S_UPD_DIV, S_UPD_WR, S_UPD_SQ, S_UPD_ACC,
		S_UPD_RS, S_UPD_ROOT, S_UPD_ADD, S_UPD_END,
		S_SPR_INIT, S_SPR_RD, S_SPR_CHK, S_EMIT
	} kce_state_t;

	typedef struct packed {
		logic              load_sample;
		logic              load_cent;
		logic              run_init;
		logic              pass_clear;
		logic              take_sample;
		logic              acc_clr;
		logic              dist_diff;
		logic              square;
		logic              dist_acc;
		logic              last_dim;
		logic              assign_wb;
		logic              sq_clr;
		logic              div_start;
		logic              div_write;
		logic              upd_acc;
		logic              root_start;
		logic              shift_add;
		logic              upd_end;
		logic              kill;
		logic              spr_clr;
		logic              spr_chk;
		logic              out_load;
		logic              out_last;
		logic [3:0]        clu;
		logic [1:0]        dim;
		logic [ITER_W-1:0] iters;
	} kce_cmd_t;

	typedef struct packed {
		logic [3:0]        nc;
		logic [2:0]        nd;
		logic [ITER_W-1:0] max_it;
		logic [7:0]        alive;
		logic              div_done;
		logic              root_done;
		logic              conv;
		logic              out_ready;
	} kce_sts_t;

	typedef struct packed {
		logic [ITER_W-1:0]                 iters;
		logic                              converged;
		logic                              valid_res;
		logic [PORT_DIMS-1:0][MEAN_W-1:0]  mean;
		logic [CNT_OUT_W-1:0]              member_count;
		logic [CID_W-1:0]                  cluster_id;
	} kce_res_t;

endpackage

// ===== sv/kce_ctrl.sv =====
// Run sequencer of the k-means engine: loads, assignment, update, spread, emit.
// Depends on kce_pkg; drives kce_dp through kce_cmd_t and reads kce_sts_t.
module kce_ctrl #(
	parameter int MAX_SAMPLES = 1024
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [1:0]                         action,
	input  kce_pkg::kce_sts_t                  sts,
	input  logic [$clog2(MAX_SAMPLES+1)-1:0]   count,
	output kce_pkg::kce_cmd_t                  cmd,
	output logic [$clog2(MAX_SAMPLES)-1:0]     addr
);
	import kce_pkg::*;

	localparam int AW    = $clog2(MAX_SAMPLES);
	localparam int CNT_W = $clog2(MAX_SAMPLES+1);

	kce_state_t        state_q, state_d;
	logic [CNT_W-1:0]  i_q, i_d, i_nx;
	logic [3:0]        c_q, c_d, c_nx;
	logic [1:0]        d_q, d_d;
	logic [ITER_W-1:0] iter_q, iter_d;
	logic              first_q, first_d;
	logic              last_d_w, last_c_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			i_q     <= '0;
			c_q     <= '0;
			d_q     <= '0;
			iter_q  <= '0;
			first_q <= 1'b0;
		end else begin
			state_q <= state_d;
			i_q     <= i_d;
			c_q     <= c_d;
			d_q     <= d_d;
			iter_q  <= iter_d;
			first_q <= first_d;
		end
	end

	assign addr     = i_q[AW-1:0];
	assign i_nx     = CNT_W'(i_q + 1'b1);
	assign c_nx     = c_q + 4'd1;
	assign last_d_w = ({1'b0, d_q} + 3'd1) == sts.nd;
	assign last_c_w = c_nx == sts.nc;

	always_comb begin
		state_d   = state_q;
		i_d       = i_q;
		c_d       = c_q;
		d_d       = d_q;
		iter_d    = iter_q;
		first_d   = first_q;
		s_tready  = 1'b0;
		cmd       = '0;
		cmd.clu   = c_q;
		cmd.dim   = d_q;
		cmd.iters = iter_q;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					case (action)
						ACT_SAMPLE: cmd.load_sample = 1'b1;
						ACT_CENT:   cmd.load_cent = 1'b1;
						ACT_RUN:    state_d = S_RUN_INIT;
						default:    ;
					endcase
				end
			end
			S_RUN_INIT: begin
				cmd.run_init = 1'b1;
				iter_d  = ITER_W'(1);
				first_d = 1'b1;
				state_d = S_PASS_INIT;
			end
			S_PASS_INIT: begin
				cmd.pass_clear = 1'b1;
				i_d = '0;
				c_d = '0;
				state_d = (count == '0) ? S_UPD_C : S_ASG_RD;
			end
			S_ASG_RD: state_d = S_ASG_LAT;
			S_ASG_LAT: begin
				cmd.take_sample = 1'b1;
				c_d = '0;
				state_d = S_ASG_CL;
			end
			S_ASG_CL: begin
				if (c_q == sts.nc) begin
					state_d = S_ASG_WB;
				end else if (!sts.alive[c_q[2:0]]) begin
					c_d = c_nx;
				end else begin
					cmd.acc_clr = 1'b1;
					d_d = '0;
					state_d = S_ASG_DIFF;
				end
			end
			S_ASG_DIFF: begin
				cmd.dist_diff = 1'b1;
				state_d = S_ASG_SQ;
			end
			S_ASG_SQ: begin
				cmd.square = 1'b1;
				state_d = S_ASG_ACC;
			end
			S_ASG_ACC: begin
				cmd.dist_acc = 1'b1;
				cmd.last_dim = last_d_w;
				if (last_d_w) begin
					c_d = c_nx;
					state_d = S_ASG_CL;
				end else begin
					d_d = d_q + 2'd1;
					state_d = S_ASG_DIFF;
				end
			end
			S_ASG_WB: begin
				cmd.assign_wb = 1'b1;
				i_d = i_nx;
				if (i_nx == count) begin
					c_d = '0;
					state_d = S_UPD_C;
				end else begin
					state_d = S_ASG_RD;
				end
			end
			S_UPD_C: begin
				if (c_q == sts.nc) begin
					state_d = S_UPD_END;
				end else begin
					cmd.sq_clr = 1'b1;
					d_d = '0;
					state_d = S_UPD_DIV0;
				end
			end
			S_UPD_DIV0: begin
				cmd.div_start = 1'b1;
				state_d = S_UPD_DIV;
			end
			S_UPD_DIV: if (sts.div_done) state_d = S_UPD_WR;
			S_UPD_WR: begin
				cmd.div_write = 1'b1;
				state_d = S_UPD_SQ;
			end
			S_UPD_SQ: begin
				cmd.square = 1'b1;
				state_d = S_UPD_ACC;
			end
			S_UPD_ACC: begin
				cmd.upd_acc = 1'b1;
				if (last_d_w) begin
					state_d = S_UPD_RS;
				end else begin
					d_d = d_q + 2'd1;
					state_d = S_UPD_DIV0;
				end
			end
			S_UPD_RS: begin
				cmd.root_start = 1'b1;
				state_d = S_UPD_ROOT;
			end
			S_UPD_ROOT: if (sts.root_done) state_d = S_UPD_ADD;
			S_UPD_ADD: begin
				cmd.shift_add = 1'b1;
				c_d = c_nx;
				state_d = S_UPD_C;
			end
			S_UPD_END: begin
				cmd.upd_end = 1'b1;
				cmd.kill = first_q;
				first_d = 1'b0;
				if (sts.conv || iter_q >= sts.max_it) begin
					state_d = S_SPR_INIT;
				end else begin
					iter_d = iter_q + 1'b1;
					state_d = S_PASS_INIT;
				end
			end
			S_SPR_INIT: begin
				cmd.spr_clr = 1'b1;
				i_d = '0;
				c_d = '0;
				state_d = (count == '0) ? S_EMIT : S_SPR_RD;
			end
			S_SPR_RD: state_d = S_SPR_CHK;
			S_SPR_CHK: begin
				cmd.spr_chk = 1'b1;
				i_d = i_nx;
				state_d = (i_nx == count) ? S_EMIT : S_SPR_RD;
			end
			S_EMIT: begin
				if (sts.out_ready) begin
					cmd.out_load = 1'b1;
					cmd.out_last = last_c_w;
					if (last_c_w) begin
						state_d = S_IDLE;
					end else begin
						c_d = c_nx;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

// ===== sv/kce_dp.sv =====
// Datapath of the k-means engine: sample and label memories, centroids, sums,
// distance multiplier, mean divider, shift square root, result register.
// Depends on kce_pkg; sequenced by kce_ctrl.
module kce_dp #(
	parameter int MAX_SAMPLES  = 1024,
	parameter int MAX_CLUSTERS = 8,
	parameter int MAX_DIMS     = 4
) (
	input  logic                                               clk,
	input  logic                                               arst_n,
	input  kce_pkg::kce_cmd_t                                  cmd,
	input  logic [$clog2(MAX_SAMPLES)-1:0]                     addr,
	output kce_pkg::kce_sts_t                                  sts,
	output logic [$clog2(MAX_SAMPLES+1)-1:0]                   count,
	input  logic                                               cfg_wr_en,
	input  logic [1:0]                                         cfg_index,
	input  logic [kce_pkg::THR_W-1:0]                          cfg_data,
	input  logic [kce_pkg::CID_W-1:0]                          cluster_index,
	input  logic [kce_pkg::PORT_DIMS-1:0][kce_pkg::VAL_W-1:0]  value,
	output kce_pkg::kce_res_t                                  res,
	output logic                                               m_tvalid,
	input  logic                                               m_tready
);
	import kce_pkg::*;

	localparam int KW    = $clog2(MAX_CLUSTERS);
	localparam int AW    = $clog2(MAX_SAMPLES);
	localparam int CNT_W = $clog2(MAX_SAMPLES+1);
	localparam int ROW_W = MAX_DIMS*VAL_W;
	localparam int SUM_W = VAL_W+AW+1;
	localparam int NW    = SUM_W+FRAC_W+1;
	localparam int DCW   = $clog2(NW+1);
	localparam int RCW   = $clog2(ROOT_STEPS+1);

	logic [3:0]        cc_q;
	logic [2:0]        dc_q;
	logic [ITER_W-1:0] mi_q;
	logic [THR_W-1:0]  th_q;
	logic [3:0]        nc;
	logic [2:0]        nd;
	logic [CNT_W-1:0]  cnt_q;

	logic [ROW_W-1:0] smem [MAX_SAMPLES];
	logic [ROW_W-1:0] srd_q;
	logic [CID_W-1:0] lmem [MAX_SAMPLES];
	logic [CID_W-1:0] lrd_q;

	logic signed [MEAN_W-1:0] cent_q [MAX_CLUSTERS][MAX_DIMS];
	logic signed [SUM_W-1:0]  sum_q  [MAX_CLUSTERS][MAX_DIMS];
	logic [CNT_W-1:0]         tot_q  [MAX_CLUSTERS];
	logic [ROW_W-1:0]         first_q [MAX_CLUSTERS];
	logic [MAX_CLUSTERS-1:0]  alive_q, have_q, spr_q;

	logic signed [VAL_W-1:0]  s_q [PORT_DIMS];
	logic signed [DIFF_W-1:0] diff_q;
	logic [SQ_W-1:0]          sq_q;
	logic [DIST_W-1:0]        acc_q, best_q, sqacc_q;
	logic [CID_W-1:0]         bestc_q;
	logic                     found_q;

	logic [NW-1:0]    dvd_q;
	logic [CNT_W-1:0] rem_q, dn_q;
	logic             neg_q;
	logic [DCW-1:0]   dcnt_q;

	logic [ROOT_W-1:0]  rx_q, rr_q, rb_q, rt;
	logic [RCW-1:0]     rcnt_q;
	logic [SHIFT_W-1:0] shtot_q;
	logic               conv_q, conv;

	kce_res_t res_q;
	logic     ov_q;

	logic [KW-1:0]            ci, li;
	logic signed [MEAN_W-1:0] cpad [PORT_DIMS];
	logic signed [SUM_W-1:0]  spad [PORT_DIMS];
	logic signed [VAL_W-1:0]  rpad [PORT_DIMS];
	logic [PORT_DIMS-1:0]     dmask;
	logic signed [MEAN_W-1:0] cur_c;
	logic signed [SUM_W-1:0]  cur_sum;
	logic [SUM_W-1:0]         mag;
	logic signed [2*DIFF_W-1:0] prod;
	logic [DIST_W-1:0]        dsum;
	logic [CNT_W:0]           rsh;
	logic                     ge;
	logic signed [MEAN_W-1:0] mnew;
	logic [ROW_W-1:0]         frow;
	logic [MAX_DIMS-1:0]      neq;
	logic                     differ;

	assign ci = cmd.clu[KW-1:0];
	assign li = lrd_q[KW-1:0];

	always_comb begin
		if (cc_q == 4'd0) nc = 4'd1;
		else if (cc_q > 4'(MAX_CLUSTERS)) nc = 4'(MAX_CLUSTERS);
		else nc = cc_q;
		if (dc_q == 3'd0) nd = 3'd1;
		else if (dc_q > 3'(MAX_DIMS)) nd = 3'(MAX_DIMS);
		else nd = dc_q;
	end

	for (genvar k = 0; k < PORT_DIMS; k++) begin : g_pad
		assign dmask[k] = 3'(k) < nd;
		if (k < MAX_DIMS) begin : g_on
			assign cpad[k] = cent_q[ci][k];
			assign spad[k] = sum_q[ci][k];
			assign rpad[k] = srd_q[k*VAL_W +: VAL_W];
		end else begin : g_off
			assign cpad[k] = '0;
			assign spad[k] = '0;
			assign rpad[k] = '0;
		end
	end

	assign cur_c   = cpad[cmd.dim];
	assign cur_sum = spad[cmd.dim];
	assign mag     = cur_sum[SUM_W-1] ? SUM_W'(-cur_sum) : SUM_W'(cur_sum);
	assign prod    = diff_q * diff_q;
	assign dsum    = acc_q + DIST_W'(sq_q);
	assign rsh     = {rem_q, dvd_q[NW-1]};
	assign ge      = rsh >= {1'b0, dn_q};
	assign mnew    = neg_q ? -signed'(dvd_q[MEAN_W-1:0]) : signed'(dvd_q[MEAN_W-1:0]);
	assign rt      = rr_q + rb_q;
	assign conv    = shtot_q < SHIFT_W'(th_q);
	assign frow    = first_q[li];

	always_comb begin
		for (int k = 0; k < MAX_DIMS; k++) begin
			neq[k] = dmask[k] && (srd_q[k*VAL_W +: VAL_W] != frow[k*VAL_W +: VAL_W]);
		end
		differ = |neq;
	end

	// configuration and sample count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cc_q  <= 4'd8;
			dc_q  <= 3'd4;
			mi_q  <= ITER_W'(20);
			th_q  <= THR_W'(256);
			cnt_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_CLUSTERS:  cc_q <= cfg_data[3:0];
					REG_DIMS:      dc_q <= cfg_data[2:0];
					REG_MAX_ITER:  mi_q <= cfg_data[ITER_W-1:0];
					REG_THRESHOLD: th_q <= cfg_data;
					default:       ;
				endcase
			end
			if (cmd.load_sample && cnt_q < CNT_W'(MAX_SAMPLES)) cnt_q <= cnt_q + 1'b1;
		end
	end

	// sample and label memories
	always_ff @(posedge clk) begin
		if (cmd.load_sample && cnt_q < CNT_W'(MAX_SAMPLES))
			smem[cnt_q[AW-1:0]] <= ROW_W'(value);
		srd_q <= smem[addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.assign_wb && found_q) lmem[addr] <= bestc_q;
		lrd_q <= lmem[addr];
	end

	// centroids and cluster sums
	always_ff @(posedge clk) begin
		if (cmd.load_cent && {1'b0, cluster_index} < 4'(MAX_CLUSTERS)) begin
			for (int k = 0; k < MAX_DIMS; k++)
				cent_q[cluster_index[KW-1:0]][k] <= {value[k], 8'h00};
		end
		if (cmd.div_write && dn_q != '0) begin
			for (int k = 0; k < MAX_DIMS; k++)
				if (2'(k) == cmd.dim) cent_q[ci][k] <= mnew;
		end
		if (cmd.pass_clear) begin
			for (int c = 0; c < MAX_CLUSTERS; c++)
				for (int k = 0; k < MAX_DIMS; k++) sum_q[c][k] <= '0;
		end else if (cmd.assign_wb && found_q) begin
			for (int k = 0; k < MAX_DIMS; k++)
				if (dmask[k])
					sum_q[bestc_q[KW-1:0]][k] <= sum_q[bestc_q[KW-1:0]][k] + SUM_W'(s_q[k]);
		end
		if (cmd.spr_chk && !have_q[li]) first_q[li] <= srd_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < MAX_CLUSTERS; c++) tot_q[c] <= '0;
			alive_q <= '1;
			have_q  <= '0;
			spr_q   <= '0;
		end else begin
			if (cmd.pass_clear) begin
				for (int c = 0; c < MAX_CLUSTERS; c++) tot_q[c] <= '0;
			end else if (cmd.assign_wb && found_q) begin
				tot_q[bestc_q[KW-1:0]] <= tot_q[bestc_q[KW-1:0]] + 1'b1;
			end
			if (cmd.run_init) begin
				alive_q <= '1;
			end else if (cmd.kill) begin
				for (int c = 0; c < MAX_CLUSTERS; c++)
					alive_q[c] <= alive_q[c] && (tot_q[c] != '0);
			end
			if (cmd.spr_clr) begin
				have_q <= '0;
				spr_q  <= '0;
			end else if (cmd.spr_chk) begin
				if (!have_q[li]) have_q[li] <= 1'b1;
				else if (differ) spr_q[li] <= 1'b1;
			end
		end
	end

	// distance and shift arithmetic
	always_ff @(posedge clk) begin
		if (cmd.take_sample) begin
			for (int k = 0; k < PORT_DIMS; k++) s_q[k] <= rpad[k];
		end
		if (cmd.dist_diff)
			diff_q <= DIFF_W'(signed'({s_q[cmd.dim], 8'h00})) - DIFF_W'(cur_c);
		else if (cmd.div_write)
			diff_q <= (dn_q != '0) ? DIFF_W'(mnew) - DIFF_W'(cur_c) : '0;
		if (cmd.square) sq_q <= SQ_W'(prod);
		if (cmd.acc_clr) acc_q <= '0;
		else if (cmd.dist_acc) acc_q <= dsum;
		if (cmd.sq_clr) sqacc_q <= '0;
		else if (cmd.upd_acc) sqacc_q <= sqacc_q + DIST_W'(sq_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			best_q  <= '0;
			bestc_q <= '0;
		end else if (cmd.take_sample) begin
			found_q <= 1'b0;
		end else if (cmd.dist_acc && cmd.last_dim && (!found_q || dsum < best_q)) begin
			found_q <= 1'b1;
			best_q  <= dsum;
			bestc_q <= cmd.clu[CID_W-1:0];
		end
	end

	// mean divider, restoring, one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
			dvd_q  <= '0;
			rem_q  <= '0;
			dn_q   <= '0;
			neg_q  <= 1'b0;
		end else if (cmd.div_start) begin
			dn_q   <= tot_q[ci];
			neg_q  <= cur_sum[SUM_W-1];
			dvd_q  <= NW'({mag, 8'h00}) + NW'(tot_q[ci] >> 1);
			rem_q  <= '0;
			dcnt_q <= DCW'(NW);
		end else if (dcnt_q != '0) begin
			rem_q  <= ge ? CNT_W'(rsh - {1'b0, dn_q}) : CNT_W'(rsh);
			dvd_q  <= {dvd_q[NW-2:0], ge};
			dcnt_q <= dcnt_q - 1'b1;
		end
	end

	// shift square root, two radicand bits per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rcnt_q  <= '0;
			rx_q    <= '0;
			rr_q    <= '0;
			rb_q    <= '0;
			shtot_q <= '0;
			conv_q  <= 1'b0;
		end else begin
			if (cmd.root_start) begin
				rx_q   <= ROOT_W'(sqacc_q);
				rr_q   <= '0;
				rb_q   <= ROOT_W'(1) << ROOT_TOP;
				rcnt_q <= RCW'(ROOT_STEPS);
			end else if (rcnt_q != '0) begin
				if (rx_q >= rt) begin
					rx_q <= rx_q - rt;
					rr_q <= (rr_q >> 1) + rb_q;
				end else begin
					rr_q <= rr_q >> 1;
				end
				rb_q   <= rb_q >> 2;
				rcnt_q <= rcnt_q - 1'b1;
			end
			if (cmd.pass_clear) shtot_q <= '0;
			else if (cmd.shift_add) shtot_q <= shtot_q + SHIFT_W'(rr_q);
			if (cmd.upd_end) conv_q <= conv;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (cmd.out_load) begin
			ov_q <= 1'b1;
		end else if (m_tready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			res_q.cluster_id   <= cmd.clu[CID_W-1:0];
			res_q.member_count <= CNT_OUT_W'(tot_q[ci]);
			for (int k = 0; k < PORT_DIMS; k++)
				res_q.mean[k] <= dmask[k] ? cpad[k] : '0;
			res_q.valid_res    <= (tot_q[ci] != '0) && spr_q[ci];
			res_q.converged    <= conv_q;
			res_q.iters        <= cmd.iters;
		end
	end

	assign res      = res_q;
	assign m_tvalid = ov_q;
	assign count    = cnt_q;

	assign sts.nc        = nc;
	assign sts.nd        = nd;
	assign sts.max_it    = mi_q;
	assign sts.alive     = 8'(alive_q);
	assign sts.div_done  = dcnt_q == '0;
	assign sts.root_done = rcnt_q == '0;
	assign sts.conv      = conv;
	assign sts.out_ready = !ov_q || m_tready;

endmodule

// ===== sv/kmeans_clustering_engine.sv =====
// Lloyd k-means clustering engine, top level.
// Depends on kce_pkg, kce_ctrl and kce_dp.
//
// Input stream (s_*): one beat per item, accepted when s_tvalid and s_tready
// are high. s_tuser carries the action: load sample, load centroid, run.
// Loads are taken one beat per cycle while the engine is idle. A run beat
// starts clustering; s_tready stays low until the last result is handed to
// the output register.
// Each pass assigns every sample to the nearest alive cluster (one shared
// 26x26 multiplier), then per cluster runs the mean divider and the square
// root of the shift; the divider works on a dividend of NW bits
// (NW = 36 with 1024 samples). After the last pass a spread check reads
// every sample, then one result beat per cluster leaves through
// m_* with m_tlast on the final cluster.
// A stalled receiver holds the result register; the next result waits.
// Reset clears the sample count and the control state and restores register
// defaults; sample and centroid contents are undefined until loaded.
module kmeans_clustering_engine #(
	parameter int MAX_SAMPLES  = 1024,
	parameter int MAX_CLUSTERS = 8,
	parameter int MAX_DIMS     = 4
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_wr_en,
	input  logic [1:0]                            cfg_index,
	input  logic [kce_pkg::THR_W-1:0]             cfg_data,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// cluster_index, value_0, value_1, value_2, value_3, zero pad
	input  logic [kce_pkg::IN_DATA_W-1:0]         s_tdata,
	// action
	input  logic [1:0]                            s_tuser,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// cluster_id, member_count, mean_0..mean_3, valid_res, converged, iterations
	output logic [kce_pkg::OUT_DATA_W-1:0]        m_tdata,
	output logic                                  m_tlast
);
	import kce_pkg::*;

	kce_cmd_t                            cmd;
	kce_sts_t                            sts;
	kce_res_t                            res;
	logic [$clog2(MAX_SAMPLES)-1:0]      addr;
	logic [$clog2(MAX_SAMPLES+1)-1:0]    count;
	logic [PORT_DIMS-1:0][VAL_W-1:0]     value;
	logic                                last_q;

	assign value = s_tdata[CID_W +: PORT_DIMS*VAL_W];

	kce_ctrl #(
		.MAX_SAMPLES(MAX_SAMPLES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.action   (s_tuser),
		.sts      (sts),
		.count    (count),
		.cmd      (cmd),
		.addr     (addr)
	);

	kce_dp #(
		.MAX_SAMPLES  (MAX_SAMPLES),
		.MAX_CLUSTERS (MAX_CLUSTERS),
		.MAX_DIMS     (MAX_DIMS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.addr          (addr),
		.sts           (sts),
		.count         (count),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.cluster_index (s_tdata[CID_W-1:0]),
		.value         (value),
		.res           (res),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready)
	);

	always_ff @(posedge clk) begin
		if (cmd.out_load) last_q <= cmd.out_last;
	end

	assign m_tdata = res;
	assign m_tlast = last_q;

endmodule
